[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, also checked through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/tmbe_pkg.sv]
package tmbe_pkg;

   localparam int CELLS  = 32768;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [16:0] PTR_LIMIT = 17'(CELLS);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_UP   = 4'd2;
   localparam logic [3:0] OP_DOWN = 4'd3;
   localparam logic [3:0] OP_OUT  = 4'd4;
   localparam logic [3:0] OP_IN   = 4'd5;
   localparam logic [3:0] OP_JZ   = 4'd6;
   localparam logic [3:0] OP_JMP  = 4'd7;
   localparam logic [3:0] OP_END  = 4'd8;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_INPUT = 2'd2;

   typedef struct packed {
      logic [3:0]        op;
      logic [7:0]        delta;
      logic [15:0]       target;
      logic [7:0]        in_byte;
      logic              in_ended;
      logic              ok;
      logic [ADDR_W-1:0] addr;
      logic              ptr_err;
   } entry_type;

   function automatic logic in_range(input logic [15:0] p);
      return {1'b0, p} < PTR_LIMIT;
   endfunction

endpackage

[src/tmbe_if.sv]
interface tmbe_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  op;
   logic [15:0] amount;
   logic [15:0] target;
   logic [7:0]  in_byte;
   logic        in_ended;

   modport source (output valid, op, amount, target, in_byte, in_ended, input ready);
   modport sink   (input valid, op, amount, target, in_byte, in_ended, output ready);
endinterface

interface tmbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_ip;
   logic        out_valid;
   logic [7:0]  out_byte;
   logic        halted;
   logic [1:0]  error;

   modport source (output valid, next_ip, out_valid, out_byte, halted, error, input ready);
   modport sink   (input valid, next_ip, out_valid, out_byte, halted, error, output ready);
endinterface

[src/tmbe_ram.sv]
module tmbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tmbe_front.sv]
module tmbe_front (
   input  logic                   clock,
   input  logic                   reset,
   tmbe_req_if.sink               req,
   input  logic                   full,
   input  logic                   clearing,
   output logic                   push,
   output tmbe_pkg::entry_type    entry
);

   logic [15:0] dp_ff, dp_in;
   logic        accept;

   assign req.ready = !full && !clearing;
   assign accept    = req.valid && req.ready;
   assign push      = accept;

   always_comb begin
      dp_in = dp_ff;
      if (req.op == tmbe_pkg::OP_UP) begin
         dp_in = dp_ff + req.amount;
      end else if (req.op == tmbe_pkg::OP_DOWN) begin
         dp_in = dp_ff - req.amount;
      end
   end

   always_comb begin
      entry.op       = req.op;
      entry.delta    = req.amount[7:0];
      entry.target   = req.target;
      entry.in_byte  = req.in_byte;
      entry.in_ended = req.in_ended;
      entry.ok       = tmbe_pkg::in_range(dp_ff);
      entry.addr     = dp_ff[tmbe_pkg::ADDR_W-1:0];
      entry.ptr_err  = !tmbe_pkg::in_range(dp_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_ff <= '0;
      end else if (accept) begin
         dp_ff <= dp_in;
      end
   end

endmodule

[src/tmbe_queue.sv]
module tmbe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tmbe_pkg::entry_type    push_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   head_valid,
   output tmbe_pkg::entry_type    head_entry
);

   tmbe_pkg::entry_type            slots_ff [tmbe_pkg::QDEPTH];
   logic [tmbe_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [tmbe_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [tmbe_pkg::QPTR_W:0]      count_ff, count_in;
   logic                           do_push, do_pop;

   assign full       = count_ff == (tmbe_pkg::QPTR_W + 1)'(tmbe_pkg::QDEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

[src/tmbe_back.sv]
module tmbe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  tmbe_pkg::entry_type    head_entry,
   output logic                   pop,
   output logic                   clearing,
   tmbe_rsp_if.source             rsp
);

   localparam int AW = tmbe_pkg::ADDR_W;

   // cell store clear sweep
   logic          clearing_ff;
   logic [AW-1:0] clr_cnt_ff;

   // execute stage
   logic                 b1_valid_ff;
   tmbe_pkg::entry_type  b1_ff;
   logic [15:0]          ip_ff;

   // last cell write, for read-modify-write forwarding
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic [7:0]    fwd_data_ff;

   // output register
   logic        rsp_valid_ff;
   logic [15:0] next_ip_ff;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        halted_ff;
   logic [1:0]  error_ff;

   logic          fire;
   logic [7:0]    rd_data;
   logic [7:0]    cur;
   logic          cell_wr;
   logic [7:0]    cell_val;
   logic [15:0]   nip;
   logic          o_valid;
   logic [7:0]    o_byte;
   logic          o_halted;
   logic [1:0]    o_error;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;

   assign clearing = clearing_ff;
   assign fire     = b1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign pop      = head_valid && !clearing_ff && (!b1_valid_ff || fire);

   always_comb begin
      if (!b1_ff.ok) begin
         cur = 8'd0;
      end else if (fwd_valid_ff && fwd_addr_ff == b1_ff.addr) begin
         cur = fwd_data_ff;
      end else begin
         cur = rd_data;
      end
   end

   always_comb begin
      cell_wr  = 1'b0;
      cell_val = cur;
      nip      = ip_ff + 16'd1;
      o_valid  = 1'b0;
      o_byte   = 8'd0;
      o_halted = 1'b0;
      o_error  = tmbe_pkg::ERR_NONE;
      unique case (b1_ff.op)
         tmbe_pkg::OP_ADD, tmbe_pkg::OP_SUB: begin
            cell_wr  = b1_ff.ok;
            cell_val = (b1_ff.op == tmbe_pkg::OP_ADD) ? cur + b1_ff.delta : cur - b1_ff.delta;
            if (!b1_ff.ok) begin
               o_error = tmbe_pkg::ERR_RANGE;
            end
         end
         tmbe_pkg::OP_UP, tmbe_pkg::OP_DOWN: begin
            if (b1_ff.ptr_err) begin
               o_error = tmbe_pkg::ERR_RANGE;
            end
         end
         tmbe_pkg::OP_OUT: begin
            if (b1_ff.ok) begin
               o_valid = 1'b1;
               o_byte  = cur;
            end else begin
               o_error = tmbe_pkg::ERR_RANGE;
            end
         end
         tmbe_pkg::OP_IN: begin
            cell_wr  = b1_ff.ok;
            cell_val = b1_ff.in_ended ? 8'hFF : b1_ff.in_byte;
            if (b1_ff.in_ended) begin
               o_error = tmbe_pkg::ERR_INPUT;
            end else if (!b1_ff.ok) begin
               o_error = tmbe_pkg::ERR_RANGE;
            end
         end
         tmbe_pkg::OP_JZ: begin
            if (!b1_ff.ok) begin
               o_error = tmbe_pkg::ERR_RANGE;
            end
            if (cur == 8'd0) begin
               nip = b1_ff.target;
            end
         end
         tmbe_pkg::OP_JMP: begin
            nip = b1_ff.target;
         end
         tmbe_pkg::OP_END: begin
            o_halted = 1'b1;
            nip      = ip_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = 8'd0;
      end else begin
         ram_wr_en   = fire && cell_wr;
         ram_wr_addr = b1_ff.addr;
         ram_wr_data = cell_val;
      end
   end

   tmbe_ram #(
      .WIDTH (8),
      .DEPTH (tmbe_pkg::CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (pop),
      .rd_addr (head_entry.addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_ff <= head_entry;
      end
      if (fire && cell_wr) begin
         fwd_addr_ff <= b1_ff.addr;
         fwd_data_ff <= cell_val;
      end
      if (fire) begin
         next_ip_ff   <= nip;
         out_valid_ff <= o_valid;
         out_byte_ff  <= o_byte;
         halted_ff    <= o_halted;
         error_ff     <= o_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         b1_valid_ff  <= 1'b0;
         ip_ff        <= '0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(tmbe_pkg::CELLS - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (pop) begin
            b1_valid_ff <= 1'b1;
         end else if (fire) begin
            b1_valid_ff <= 1'b0;
         end
         if (fire) begin
            ip_ff <= nip;
         end
         if (fire && cell_wr) begin
            fwd_valid_ff <= 1'b1;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.next_ip   = next_ip_ff;
   assign rsp.out_valid = out_valid_ff;
   assign rsp.out_byte  = out_byte_ff;
   assign rsp.halted    = halted_ff;
   assign rsp.error     = error_ff;

endmodule

[src/tape_machine_bytecode_executor_core.sv]
// channel    dir  handshake       word
// req_chan   in   valid / ready   op, amount, target, in_byte, in_ended
// rsp_chan   out  valid / ready   next_ip, out_valid, out_byte, halted, error
//
// Sustains one instruction per cycle while rsp_chan is ready; a word passes through the
// queue, cell read and output register. Cell read-modify-write runs on one RAM with
// forwarding of the last write. After reset a sweep zeroes all 32768 cells, one per
// cycle, with req_chan.ready low. A stalled rsp_chan backs up through the queue.
module tape_machine_bytecode_executor_core (
   input  logic          clock,
   input  logic          reset,
   tmbe_req_if.sink      req_chan,
   tmbe_rsp_if.source    rsp_chan
);

   tmbe_pkg::entry_type push_entry;
   tmbe_pkg::entry_type head_entry;
   logic                push;
   logic                pop;
   logic                full;
   logic                head_valid;
   logic                clearing;

   tmbe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .full     (full),
      .clearing (clearing),
      .push     (push),
      .entry    (push_entry)
   );

   tmbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tmbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .clearing   (clearing),
      .rsp        (rsp_chan)
   );

endmodule

[src/tmbe_checker.sv]
`include "assert_macros.svh"

module tmbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_next_ip,
   input logic        rsp_out_valid,
   input logic        rsp_halted,
   input logic [1:0]  rsp_error
);

   logic stalled;
   logic err_none;
   logic err_known;

   assign stalled   = rsp_valid && !rsp_ready;
   assign err_none  = rsp_error == tmbe_pkg::ERR_NONE;
   assign err_known = err_none || rsp_error == tmbe_pkg::ERR_RANGE ||
                      rsp_error == tmbe_pkg::ERR_INPUT;

   `ASSERT_NEXT_ALWAYS(a_idle_after_reset, clock, reset, !rsp_valid)

   `ASSERT_NEXT(a_rsp_holds, clock, reset, stalled, rsp_valid && $stable(rsp_next_ip))

   `ASSERT_IMPLY(a_out_no_error, clock, reset, rsp_valid && rsp_out_valid, err_none && !rsp_halted)

   `ASSERT_IMPLY(a_halt_clean, clock, reset, rsp_valid && rsp_halted, err_none)

   `ASSERT_IMPLY(a_error_code, clock, reset, rsp_valid, err_known)

endmodule

bind tape_machine_bytecode_executor_core tmbe_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_next_ip   (rsp_chan.next_ip),
   .rsp_out_valid (rsp_chan.out_valid),
   .rsp_halted    (rsp_chan.halted),
   .rsp_error     (rsp_chan.error)
);
